@@ rtl/qed_pkg.sv @@
// ----------------------------------------------------------------------------
// qed_pkg
// Shared sizes, codes and control types of the quadrature edge decoder.
// ----------------------------------------------------------------------------
package qed_pkg;

    localparam int MOTORS     = 2;
    localparam int COUNT_BITS = 16;

    localparam int TIME_BITS  = 32;
    localparam int POS_BITS   = 32;
    localparam int SPUR_BITS  = 16;
    localparam int EC_BITS    = 16;
    localparam int ERR_BITS   = 16;
    localparam int KIND_BITS  = 2;

    localparam int KINDS      = MOTORS * 4;
    localparam int KIDX_BITS  = $clog2(KINDS);
    localparam int BIDX_BITS  = $clog2(2 * KINDS);
    localparam int MOTOR_BITS = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    // Wide enough for four saturated error counters plus one.
    localparam int ESUM_BITS  = SPUR_BITS + 2;

    localparam logic [KIDX_BITS-1:0] LAST_KIDX = KIDX_BITS'(KINDS - 1);

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [KIND_BITS-1:0] KIND_A_RISE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_A_FALL = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_B_RISE = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_B_FALL = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } t_ctrl_state;

    typedef struct packed {
        logic                 edge_en;
        logic                 tick_flip;
        logic                 tick_emit;
        logic [KIDX_BITS-1:0] idx;
        logic                 last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/qed_in_if.sv @@
// ----------------------------------------------------------------------------
// qed_in_if
// Request channel: pin edge events and sample ticks.
// ----------------------------------------------------------------------------
interface qed_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        motor_index;
    logic        from_pin_a;
    logic        level_a;
    logic        level_b;
    logic [31:0] edge_time;

    modport source (
        output valid, req_type, motor_index, from_pin_a, level_a, level_b, edge_time,
        input  ready
    );
    modport sink (
        input  valid, req_type, motor_index, from_pin_a, level_a, level_b, edge_time,
        output ready
    );
endinterface

@@ rtl/qed_out_if.sv @@
// ----------------------------------------------------------------------------
// qed_out_if
// Result channel: one beat per edge, one beat per counter on a tick.
// ----------------------------------------------------------------------------
interface qed_out_if;
    logic               valid;
    logic               ready;
    logic               motor_out;
    logic [1:0]         edge_kind;
    logic               spurious;
    logic               reverse_dir;
    logic [31:0]        position;
    logic signed [15:0] edge_count;
    logic [31:0]        edge_time_out;
    logic [15:0]        error_total;
    logic               last_of_run;

    modport source (
        output valid, motor_out, edge_kind, spurious, reverse_dir, position,
               edge_count, edge_time_out, error_total, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, motor_out, edge_kind, spurious, reverse_dir, position,
               edge_count, edge_time_out, error_total, last_of_run,
        output ready
    );
endinterface

@@ rtl/qed_ctrl.sv @@
// ----------------------------------------------------------------------------
// qed_ctrl
// Request sequencer: takes edges directly and walks the closed bank on a tick.
// ----------------------------------------------------------------------------
module qed_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_req_type,
    output logic                o_in_ready,
    input  qed_pkg::t_dp_status i_status,
    output qed_pkg::t_dp_cmd    o_cmd
);
    import qed_pkg::*;

    t_ctrl_state          r_state, n_state;
    logic [KIDX_BITS-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_in_ready    = 1'b0;
        o_cmd.edge_en   = 1'b0;
        o_cmd.tick_flip = 1'b0;
        o_cmd.tick_emit = 1'b0;
        o_cmd.idx       = r_idx;
        o_cmd.last      = (r_idx == LAST_KIDX);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_req_type == REQ_TICK) begin
                        o_cmd.tick_flip = 1'b1;
                        n_idx           = '0;
                        n_state         = ST_TICK;
                    end else begin
                        o_cmd.edge_en = 1'b1;
                    end
                end
            end
            ST_TICK: begin
                // One counter beat whenever the output register can take it.
                if (i_status.out_free) begin
                    o_cmd.tick_emit = 1'b1;
                    if (r_idx == LAST_KIDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/qed_datapath.sv @@
// ----------------------------------------------------------------------------
// qed_datapath
// Decoder state, bank counters, error counters and the output register.
// ----------------------------------------------------------------------------
module qed_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  qed_pkg::t_dp_cmd                i_cmd,
    output qed_pkg::t_dp_status             o_status,
    input  logic                            i_motor_index,
    input  logic                            i_from_pin_a,
    input  logic                            i_level_a,
    input  logic                            i_level_b,
    input  logic [qed_pkg::TIME_BITS-1:0]   i_edge_time,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_motor_out,
    output logic [qed_pkg::KIND_BITS-1:0]   o_edge_kind,
    output logic                            o_spurious,
    output logic                            o_reverse_dir,
    output logic [qed_pkg::POS_BITS-1:0]    o_position,
    output logic signed [qed_pkg::EC_BITS-1:0] o_edge_count,
    output logic [qed_pkg::TIME_BITS-1:0]   o_edge_time_out,
    output logic [qed_pkg::ERR_BITS-1:0]    o_error_total,
    output logic                            o_last_of_run
);
    import qed_pkg::*;

    logic                         r_prev_a [MOTORS];
    logic                         r_prev_b [MOTORS];
    logic                         r_dir    [MOTORS];
    logic [POS_BITS-1:0]          r_pos    [MOTORS];
    logic [SPUR_BITS-1:0]         r_spur   [KINDS];
    logic signed [COUNT_BITS-1:0] r_cnt    [2*KINDS];
    logic [TIME_BITS-1:0]         r_time   [2*KINDS];
    logic                         r_bank;
    logic                         r_out_valid;

    logic                         r_motor_out;
    logic [KIND_BITS-1:0]         r_edge_kind;
    logic                         r_spurious;
    logic                         r_reverse_dir;
    logic [POS_BITS-1:0]          r_position;
    logic signed [EC_BITS-1:0]    r_edge_count;
    logic [TIME_BITS-1:0]         r_edge_time_out;
    logic [ERR_BITS-1:0]          r_error_total;
    logic                         r_last_of_run;

    function automatic logic [BIDX_BITS-1:0] bank_index(input logic bank,
                                                       input logic [KIDX_BITS-1:0] kidx);
        return BIDX_BITS'(kidx) + (bank ? BIDX_BITS'(KINDS) : BIDX_BITS'(0));
    endfunction

    logic                         motor_ok, edge_go, tick;
    logic [MOTOR_BITS-1:0]        m_e, m_t, rd_m;
    logic                         lvl, prev_lvl, spur, rev;
    logic [KIND_BITS-1:0]         kind_e;
    logic [KIDX_BITS-1:0]         kidx_e, sidx_e, base_rd;
    logic [BIDX_BITS-1:0]         rd_bidx;
    logic signed [COUNT_BITS-1:0] cnt_rd, n_cnt;
    logic [TIME_BITS-1:0]         time_rd;
    logic [POS_BITS-1:0]          pos_rd, n_pos;
    logic                         spur_bump;
    logic [ESUM_BITS-1:0]         err_sum;
    logic [ERR_BITS-1:0]          err_sat;

    always_comb begin
        motor_ok = (32'(i_motor_index) < MOTORS);
        edge_go  = i_cmd.edge_en && motor_ok;
        tick     = i_cmd.tick_emit;
        m_e      = MOTOR_BITS'(i_motor_index);
        m_t      = MOTOR_BITS'(i_cmd.idx >> 2);
        rd_m     = tick ? m_t : m_e;

        lvl      = i_from_pin_a ? i_level_a : i_level_b;
        prev_lvl = i_from_pin_a ? r_prev_a[m_e] : r_prev_b[m_e];
        spur     = (lvl == prev_lvl);
        rev      = i_from_pin_a ? (i_level_a == i_level_b) : (i_level_a != i_level_b);
        if (i_from_pin_a) begin
            kind_e = i_level_a ? KIND_A_RISE : KIND_A_FALL;
        end else begin
            kind_e = i_level_b ? KIND_B_RISE : KIND_B_FALL;
        end
        kidx_e  = (KIDX_BITS'(m_e) << 2) | KIDX_BITS'(kind_e);
        // Error counters are ordered A low, A high, B low, B high.
        sidx_e  = (KIDX_BITS'(m_e) << 2) | KIDX_BITS'({~i_from_pin_a, lvl});
        base_rd = KIDX_BITS'(rd_m) << 2;

        rd_bidx = tick ? bank_index(~r_bank, i_cmd.idx) : bank_index(r_bank, kidx_e);
        cnt_rd  = r_cnt[rd_bidx];
        time_rd = r_time[rd_bidx];
        pos_rd  = r_pos[rd_m];

        n_pos = rev ? pos_rd - 1'b1 : pos_rd + 1'b1;
        if (rev) begin
            n_cnt = (cnt_rd == CNT_MIN) ? cnt_rd : cnt_rd - $signed(COUNT_BITS'(1));
        end else begin
            n_cnt = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + $signed(COUNT_BITS'(1));
        end

        // A saturated counter does not move, so the total grows by one at most.
        spur_bump = !tick && spur && (r_spur[sidx_e] != '1);
        err_sum   = ESUM_BITS'(r_spur[base_rd]) + ESUM_BITS'(r_spur[base_rd + 2'd1])
                  + ESUM_BITS'(r_spur[base_rd + 2'd2]) + ESUM_BITS'(r_spur[base_rd + 2'd3])
                  + ESUM_BITS'(spur_bump);
        err_sat   = (err_sum > ESUM_BITS'({ERR_BITS{1'b1}})) ? '1 : err_sum[ERR_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTORS; i++) begin
                r_prev_a[i] <= 1'b0;
                r_prev_b[i] <= 1'b0;
                r_dir[i]    <= 1'b0;
                r_pos[i]    <= '0;
            end
            for (int i = 0; i < KINDS; i++) begin
                r_spur[i] <= '0;
            end
            for (int i = 0; i < 2*KINDS; i++) begin
                r_cnt[i]  <= '0;
                r_time[i] <= '0;
            end
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (edge_go) begin
                if (i_from_pin_a) begin
                    r_prev_a[m_e] <= i_level_a;
                end else begin
                    r_prev_b[m_e] <= i_level_b;
                end
                r_dir[m_e] <= rev;
                if (spur_bump) begin
                    r_spur[sidx_e] <= r_spur[sidx_e] + 1'b1;
                end
                if (!spur) begin
                    r_pos[m_e]     <= n_pos;
                    r_cnt[rd_bidx]  <= n_cnt;
                    r_time[rd_bidx] <= i_edge_time;
                end
            end
            if (i_cmd.tick_flip) begin
                r_bank <= ~r_bank;
            end
            if (tick) begin
                r_cnt[rd_bidx] <= '0;
            end
            if (edge_go || tick) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_motor_out     <= m_t[0];
            r_edge_kind     <= i_cmd.idx[KIND_BITS-1:0];
            r_spurious      <= 1'b0;
            r_reverse_dir   <= r_dir[m_t];
            r_position      <= pos_rd;
            r_edge_count    <= EC_BITS'(cnt_rd);
            r_edge_time_out <= time_rd;
            r_error_total   <= err_sat;
            r_last_of_run   <= i_cmd.last;
        end else if (edge_go) begin
            r_motor_out     <= i_motor_index;
            r_edge_kind     <= kind_e;
            r_spurious      <= spur;
            r_reverse_dir   <= rev;
            r_position      <= spur ? pos_rd : n_pos;
            r_edge_count    <= EC_BITS'(spur ? cnt_rd : n_cnt);
            r_edge_time_out <= spur ? time_rd : i_edge_time;
            r_error_total   <= err_sat;
            r_last_of_run   <= 1'b1;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_motor_out       = r_motor_out;
    assign o_edge_kind       = r_edge_kind;
    assign o_spurious        = r_spurious;
    assign o_reverse_dir     = r_reverse_dir;
    assign o_position        = r_position;
    assign o_edge_count      = r_edge_count;
    assign o_edge_time_out   = r_edge_time_out;
    assign o_error_total     = r_error_total;
    assign o_last_of_run     = r_last_of_run;

endmodule

@@ rtl/quadrature_edge_decoder.sv @@
// An edge beat is registered and valid the cycle after the edge is taken. A tick flips the
// bank in ST_IDLE; ST_TICK loads the first counter beat once the output register has room.
// Edges are taken one per cycle while the output register has room; during a tick the
// sequencer walks the closed bank one counter beat at a time, holding off requests.
// The output register decouples the sides: a new request is taken as the last beat leaves.
// Reset is synchronous, active low, and clears all decoder state at once.
// ----------------------------------------------------------------------------
// quadrature_edge_decoder
// Two-encoder x4 quadrature decoder with double-banked edge counters.
// ----------------------------------------------------------------------------
module quadrature_edge_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qed_in_if.sink           i_in,
    qed_out_if.source        o_out
);
    import qed_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_accept;

    qed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    qed_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_motor_index   (i_in.motor_index),
        .i_from_pin_a    (i_in.from_pin_a),
        .i_level_a       (i_in.level_a),
        .i_level_b       (i_in.level_b),
        .i_edge_time     (i_in.edge_time),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_motor_out     (o_out.motor_out),
        .o_edge_kind     (o_out.edge_kind),
        .o_spurious      (o_out.spurious),
        .o_reverse_dir   (o_out.reverse_dir),
        .o_position      (o_out.position),
        .o_edge_count    (o_out.edge_count),
        .o_edge_time_out (o_out.edge_time_out),
        .o_error_total   (o_out.error_total),
        .o_last_of_run   (o_out.last_of_run)
    );

    assign in_accept = i_in.valid && i_in.ready;

    // A request is only taken when the output register has room for its beat.
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!o_out.valid || o_out.ready))
        else $error("request taken while output register is full");

    // A tick blocks further requests while its counter beats drain.
    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.req_type == REQ_TICK) |=> !i_in.ready)
        else $error("request taken during tick drain");

    // Every edge on a known motor produces a beat in the next cycle.
    a_edge_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.req_type == REQ_EDGE && 32'(i_in.motor_index) < MOTORS)
        |=> (o_out.valid && o_out.last_of_run))
        else $error("edge beat missing");

    // Rejected edges never come from a tick drain, so they always end their run.
    a_spur_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.spurious) |-> o_out.last_of_run)
        else $error("spurious beat not marked last");

endmodule

@@ verif/quadrature_edge_decoder_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadrature_edge_decoder_test
// Self-checking bench for the two-encoder x4 quadrature decoder. A driver
// feeds edge and tick requests from a queue, a tracking model of the decoder
// predicts every result beat, and a monitor compares each accepted beat with
// the oldest prediction. The run covers directed corner cases, a short soak
// of counting and repeated levels, and random quadrature traffic under
// several idle and stall mixes.
// ----------------------------------------------------------------------------
module quadrature_edge_decoder_test;
    import qed_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_PER_PHASE = 66;
    localparam int SOAK_PAIRS = 12;

    typedef struct packed {
        logic        req_type;
        logic        motor;
        logic        pin_a;
        logic        lvl_a;
        logic        lvl_b;
        logic [31:0] stamp;
    } t_edge_req;

    typedef struct packed {
        logic               motor;
        logic [1:0]         kind;
        logic               spur;
        logic               rev;
        logic [31:0]        pos;
        logic signed [15:0] count;
        logic [31:0]        stamp;
        logic [15:0]        err;
        logic               last;
    } t_decode_res;

    logic i_clk;
    logic i_rst_n;

    qed_in_if  req_ch ();
    qed_out_if res_ch ();

    quadrature_edge_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // Tracking copy of the decoder state.
    logic                         prev_a [MOTORS];
    logic                         prev_b [MOTORS];
    logic                         dir_down [MOTORS];
    logic [31:0]                  pos_cnt [MOTORS];
    logic [15:0]                  spur_cnt [KINDS];
    logic signed [COUNT_BITS-1:0] bank_cnt [2*KINDS];
    logic [31:0]                  bank_stamp [2*KINDS];
    logic                         act_bank;

    // Stimulus-side view of the pin levels, used to build legal x4 sequences.
    logic        gen_a [MOTORS];
    logic        gen_b [MOTORS];
    logic [31:0] stamp_now;

    t_edge_req   pending_reqs[$];
    t_decode_res expected_beats[$];
    t_edge_req   cur_req;
    t_decode_res got_beat;
    t_decode_res want_beat;

    int tx_idle_pct;
    int rx_stall_pct;
    int n_errors;
    int n_edges;
    int n_spur;
    int n_ticks;
    int n_beats;
    int quiet_cycles;

    always #5 i_clk = ~i_clk;

    function automatic t_decode_res status_beat(int m, logic [1:0] kind, logic spur,
                                                 logic rev, int idx, logic last);
        t_decode_res r;
        logic [ESUM_BITS-1:0] esum;
        esum = '0;
        for (int i = 0; i < 4; i++) esum += ESUM_BITS'(spur_cnt[m*4 + i]);
        r.motor = m[0];
        r.kind  = kind;
        r.spur  = spur;
        r.rev   = rev;
        r.pos   = pos_cnt[m];
        r.count = EC_BITS'(bank_cnt[idx]);
        r.stamp = bank_stamp[idx];
        r.err   = (esum > ESUM_BITS'(16'hFFFF)) ? 16'hFFFF : esum[15:0];
        r.last  = last;
        return r;
    endfunction

    function void decode_request(t_edge_req rq);
        int m;
        int idx;
        int sidx;
        int closed;
        logic [1:0] kind;
        logic spur;
        logic rev;
        if (rq.req_type == REQ_TICK) begin
            n_ticks++;
            closed   = int'(act_bank);
            act_bank = ~act_bank;
            for (int mm = 0; mm < MOTORS; mm++) begin
                for (int k = 0; k < 4; k++) begin
                    idx = closed*KINDS + mm*4 + k;
                    expected_beats.push_back(status_beat(mm, k[1:0], 1'b0, dir_down[mm], idx,
                                                         (mm == MOTORS-1) && (k == 3)));
                    bank_cnt[idx] = '0;
                end
            end
        end else begin
            n_edges++;
            m = int'(rq.motor);
            if (rq.pin_a) begin
                rev       = (rq.lvl_a == rq.lvl_b);
                spur      = (rq.lvl_a == prev_a[m]);
                prev_a[m] = rq.lvl_a;
                kind      = rq.lvl_a ? KIND_A_RISE : KIND_A_FALL;
                sidx      = m*4 + int'(rq.lvl_a);
            end else begin
                rev       = (rq.lvl_a != rq.lvl_b);
                spur      = (rq.lvl_b == prev_b[m]);
                prev_b[m] = rq.lvl_b;
                kind      = rq.lvl_b ? KIND_B_RISE : KIND_B_FALL;
                sidx      = m*4 + 2 + int'(rq.lvl_b);
            end
            if (spur) begin
                n_spur++;
                if (spur_cnt[sidx] != 16'hFFFF) spur_cnt[sidx]++;
            end
            dir_down[m] = rev;
            idx = int'(act_bank)*KINDS + m*4 + int'(kind);
            if (!spur) begin
                pos_cnt[m] = rev ? pos_cnt[m] - 1 : pos_cnt[m] + 1;
                if (rev && bank_cnt[idx] != CNT_MIN) bank_cnt[idx] = bank_cnt[idx] - 1;
                if (!rev && bank_cnt[idx] != CNT_MAX) bank_cnt[idx] = bank_cnt[idx] + 1;
                bank_stamp[idx] = rq.stamp;
            end
            expected_beats.push_back(status_beat(m, kind, spur, rev, idx, 1'b1));
        end
    endfunction

    function logic [31:0] next_stamp();
        if ($urandom_range(15) == 0) stamp_now = $urandom();
        else stamp_now = stamp_now + $urandom_range(1, 3000);
        return stamp_now;
    endfunction

    function void queue_edge(int m, logic pin_a, logic la, logic lb, logic [31:0] stamp);
        t_edge_req rq;
        rq.req_type = REQ_EDGE;
        rq.motor    = m[0];
        rq.pin_a    = pin_a;
        rq.lvl_a    = la;
        rq.lvl_b    = lb;
        rq.stamp    = stamp;
        if (pin_a) gen_a[m] = la;
        else gen_b[m] = lb;
        pending_reqs.push_back(rq);
    endfunction

    // The edge fields of a tick are don't-care, so they carry random bits.
    function void queue_tick();
        t_edge_req rq;
        rq          = t_edge_req'($bits(t_edge_req)'({$urandom(), $urandom()}));
        rq.req_type = REQ_TICK;
        pending_reqs.push_back(rq);
    endfunction

    function void queue_random_item();
        int  pick;
        int  m;
        logic fwd;
        pick = $urandom_range(99);
        m    = $urandom_range(MOTORS-1);
        if (pick < 8) begin
            queue_tick();
        end else if (pick < 82) begin
            // Forward x4 order is A rise, B rise, A fall, B fall.
            fwd = ($urandom_range(3) != 0);
            if ((gen_a[m] == gen_b[m]) == fwd) queue_edge(m, 1'b1, ~gen_a[m], gen_b[m], next_stamp());
            else queue_edge(m, 1'b0, gen_a[m], ~gen_b[m], next_stamp());
        end else begin
            queue_edge(m, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       next_stamp());
        end
    endfunction

    function string beat_str(t_decode_res b);
        return $sformatf("m%0d kind %0d spur %0d rev %0d pos %h cnt %0d t %h err %0d last %0d",
                         b.motor, b.kind, b.spur, b.rev, b.pos, b.count, b.stamp, b.err, b.last);
    endfunction

    // Checked at the falling edge so every update of the rising edge has settled.
    task wait_idle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_beats.size() != 0);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) decode_request(cur_req);
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.req_type    <= cur_req.req_type;
                    req_ch.motor_index <= cur_req.motor;
                    req_ch.from_pin_a  <= cur_req.pin_a;
                    req_ch.level_a     <= cur_req.lvl_a;
                    req_ch.level_b     <= cur_req.lvl_b;
                    req_ch.edge_time   <= cur_req.stamp;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_beats++;
            got_beat.motor = res_ch.motor_out;
            got_beat.kind  = res_ch.edge_kind;
            got_beat.spur  = res_ch.spurious;
            got_beat.rev   = res_ch.reverse_dir;
            got_beat.pos   = res_ch.position;
            got_beat.count = res_ch.edge_count;
            got_beat.stamp = res_ch.edge_time_out;
            got_beat.err   = res_ch.error_total;
            got_beat.last  = res_ch.last_of_run;
            if (expected_beats.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("Unexpected beat: %s", beat_str(got_beat));
            end else begin
                want_beat = expected_beats.pop_front();
                if (got_beat !== want_beat) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("Mismatch on beat %0d", n_beats);
                        $display("  expected %s", beat_str(want_beat));
                        $display("  actual   %s", beat_str(got_beat));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = 1'b0;
        req_ch.motor_index = 1'b0;
        req_ch.from_pin_a  = 1'b0;
        req_ch.level_a     = 1'b0;
        req_ch.level_b     = 1'b0;
        req_ch.edge_time   = '0;
        res_ch.ready       = 1'b0;
        tx_idle_pct        = 0;
        rx_stall_pct       = 0;
        n_errors           = 0;
        n_edges            = 0;
        n_spur             = 0;
        n_ticks            = 0;
        n_beats            = 0;
        quiet_cycles       = 0;
        stamp_now          = $urandom();
        act_bank           = 1'b0;
        for (int m = 0; m < MOTORS; m++) begin
            prev_a[m]   = 1'b0;
            prev_b[m]   = 1'b0;
            dir_down[m] = 1'b0;
            pos_cnt[m]  = '0;
            gen_a[m]    = 1'b0;
            gen_b[m]    = 1'b0;
        end
        for (int i = 0; i < KINDS; i++) spur_cnt[i] = '0;
        for (int i = 0; i < 2*KINDS; i++) begin
            bank_cnt[i]   = '0;
            bank_stamp[i] = '0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty harvest, repeated levels, a downward position wrap,
        // a full forward cycle, a reverse step and back-to-back ticks.
        queue_tick();
        queue_edge(0, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
        queue_edge(0, 1'b1, 1'b1, 1'b0, 32'h0000_0000);
        queue_edge(0, 1'b1, 1'b0, 1'b0, 32'h8000_0000);
        queue_edge(0, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF);
        queue_edge(0, 1'b0, 1'b0, 1'b1, 32'h5555_5555);
        queue_edge(0, 1'b0, 1'b0, 1'b1, 32'hAAAA_AAAA);
        queue_edge(0, 1'b0, 1'b1, 1'b0, 32'h1234_5678);
        queue_edge(1, 1'b1, 1'b1, 1'b0, 32'd10);
        queue_edge(1, 1'b0, 1'b1, 1'b1, 32'd20);
        queue_edge(1, 1'b1, 1'b0, 1'b1, 32'd30);
        queue_edge(1, 1'b0, 1'b0, 1'b0, 32'd40);
        queue_edge(1, 1'b0, 1'b0, 1'b1, 32'd50);
        queue_edge(1, 1'b0, 1'b0, 1'b1, 32'd60);
        queue_tick();
        queue_tick();
        queue_tick();
        // Hold the sender until every result of the directed part is back.
        wait_idle();

        // Soak: motor 0 toggles only pin A with B low, so A rises count up and
        // A falls count down; motor 1 repeats a B level to pile up error counts.
        queue_tick();
        for (int i = 0; i < SOAK_PAIRS; i++) begin
            queue_edge(0, 1'b1, ~gen_a[0], 1'b0, next_stamp());
            queue_edge(1, 1'b0, gen_a[1], gen_b[1], next_stamp());
            while (pending_reqs.size() > 32) @(posedge i_clk);
        end
        queue_tick();
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++) queue_random_item();
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (expected_beats.size() != 0) n_errors++;
        $display("Covered %0d edges (%0d repeated levels) and %0d ticks; %0d result beats checked.",
                 n_edges, n_spur, n_ticks, n_beats);
        $display("Included position wrap, bank harvests, error totals and four idle/stall mixes.");
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failing beats", n_errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ quadrature_edge_decoder.f @@
rtl/qed_pkg.sv
rtl/qed_in_if.sv
rtl/qed_out_if.sv
rtl/qed_ctrl.sv
rtl/qed_datapath.sv
rtl/quadrature_edge_decoder.sv
verif/quadrature_edge_decoder_test.sv
